FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the edge fader RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/rcef_pkg.sv
// ----------------------------------------------------------------------------
// rcef_pkg
// Types, constants and table helper for the raised-cosine edge fader.
// ----------------------------------------------------------------------------
`default_nettype none

package rcef_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int LEN_W      = 17;
    localparam int HUND_W     = 14;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_MAX_LENGTH      = 65536;
    localparam int DEF_COS_TABLE_DEPTH = 1024;
    localparam int DEF_IDX_W           = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT      = 2'd2;

    localparam logic [HUND_W-1:0] FULL_HUNDREDTHS = 14'd10000;
    localparam logic [HUND_W-1:0] HALF_HUNDREDTHS = 14'd5000;
    localparam logic [GAIN_W-1:0] ONE_Q15         = 16'd32768;
    localparam logic [63:0]       HALF_PI_Q30     = 64'd1686629713;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] nin;
        logic [LEN_W-1:0] nout;
        logic             busy;
    } t_fade_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [LEN_W-1:0]           in_pos;
        logic [LEN_W-1:0]           out_pos;
        logic                       in_act;
        logic                       out_act;
        logic                       last;
    } t_job;

    typedef enum logic [1:0] {
        CFG_IDLE,
        CFG_MUL,
        CFG_DIV
    } t_cfg_state;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SETUP,
        BK_DIVQ,
        BK_ROM,
        BK_MULD,
        BK_DIVF,
        BK_GMUL,
        BK_ROUND,
        BK_OUT
    } t_back_state;

    // Q2.30 sine, Taylor series up to the x^15 term; elaboration use only
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - term;
        return sum;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rcef_cfg.sv
// ----------------------------------------------------------------------------
// rcef_cfg
// Configuration registers and fade-length derivation (reciprocal /10000).
// ----------------------------------------------------------------------------
`default_nettype none

module rcef_cfg #(
    parameter int MAX_LENGTH = rcef_pkg::DEF_MAX_LENGTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rcef_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcef_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rcef_pkg::t_fade_cfg              o_cfg
);
    import rcef_pkg::*;

    localparam int DV_W        = LEN_W + HUND_W;
    // 10000 = 16 * 625: shift out the 16, then multiply by ceil(2^36 / 625)
    localparam int PRE_SHIFT   = 4;
    localparam int NUM_W       = DV_W - PRE_SHIFT;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 36;
    localparam int RPROD_W     = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_625 = 27'd109951163;

    t_cfg_state r_state, n_state;

    logic [LEN_W-1:0]  r_len;
    logic [HUND_W-1:0] r_hin;
    logic [HUND_W-1:0] r_hout;
    logic [LEN_W-1:0]  r_nin;
    logic [LEN_W-1:0]  r_nout;
    logic              r_phase;
    logic [DV_W-1:0]   r_acc;

    logic               wr_len, wr_hin, wr_hout, write_hit;
    logic [LEN_W-1:0]   len_clamped;
    logic [HUND_W-1:0]  hund_clamped;
    logic               busy, load, step;
    logic [HUND_W-1:0]  h_sel;
    logic [RPROD_W-1:0] recip_p;
    logic [LEN_W-1:0]   quot;

    assign wr_len    = i_cfg_we && (i_cfg_index == REG_BUFFER_LENGTH);
    assign wr_hin    = i_cfg_we && (i_cfg_index == REG_FADE_IN);
    assign wr_hout   = i_cfg_we && (i_cfg_index == REG_FADE_OUT);
    assign write_hit = wr_len || wr_hin || wr_hout;

    always_comb begin
        if (i_cfg_data == '0) begin
            len_clamped = LEN_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_LENGTH)) begin
            len_clamped = LEN_W'(MAX_LENGTH);
        end else begin
            len_clamped = i_cfg_data[LEN_W-1:0];
        end
        if (i_cfg_data[HUND_W-1:0] > FULL_HUNDREDTHS) begin
            hund_clamped = FULL_HUNDREDTHS;
        end else begin
            hund_clamped = i_cfg_data[HUND_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            CFG_IDLE: n_state = CFG_IDLE;
            CFG_MUL:  n_state = CFG_DIV;
            CFG_DIV:  n_state = r_phase ? CFG_IDLE : CFG_MUL;
            default:  n_state = CFG_IDLE;
        endcase
        // any write restarts both derivations
        if (write_hit) begin
            n_state = CFG_MUL;
        end
    end

    // outputs
    always_comb begin
        load = 1'b0;
        step = 1'b0;
        busy = i_cfg_we;
        case (r_state)
            CFG_IDLE: ;
            CFG_MUL: begin
                load = 1'b1;
                busy = 1'b1;
            end
            CFG_DIV: begin
                step = 1'b1;
                busy = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

    assign h_sel   = r_phase ? r_hout : r_hin;
    assign recip_p = RPROD_W'(r_acc[DV_W-1:PRE_SHIFT]) * RPROD_W'(RECIP_625);
    assign quot    = recip_p[RECIP_SHIFT +: LEN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CFG_IDLE;
            r_len   <= LEN_W'(1);
            r_hin   <= '0;
            r_hout  <= '0;
            r_nin   <= '0;
            r_nout  <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_len) begin
                r_len <= len_clamped;
            end
            if (wr_hin) begin
                r_hin <= hund_clamped;
            end
            if (wr_hout) begin
                r_hout <= hund_clamped;
            end
            if (write_hit) begin
                r_phase <= 1'b0;
            end else if (step) begin
                if (r_phase) begin
                    r_nout <= quot;
                end else begin
                    r_nin <= quot;
                end
                r_phase <= 1'b1;
            end
        end
    end

    // len * h + 5000, divided by 10000 in the following cycle
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_acc <= DV_W'(r_len) * DV_W'(h_sel) + DV_W'(HALF_HUNDREDTHS);
        end
    end

    assign o_cfg.len  = r_len;
    assign o_cfg.nin  = r_nin;
    assign o_cfg.nout = r_nout;
    assign o_cfg.busy = busy;

endmodule

`default_nettype wire

FILE: rtl/rcef_front.sv
// ----------------------------------------------------------------------------
// rcef_front
// Takes sample requests, tracks the buffer position and tags fade coverage.
// ----------------------------------------------------------------------------
`default_nettype none

module rcef_front #(
    parameter int IDX_W = rcef_pkg::DEF_IDX_W
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [rcef_pkg::SAMPLE_W-1:0] i_sample_in,
    input  rcef_pkg::t_fade_cfg                  i_cfg,
    input  logic                                 i_queue_full,
    output logic                                 o_push,
    output rcef_pkg::t_job                       o_job
);
    import rcef_pkg::*;

    logic [IDX_W-1:0] r_index;
    logic [LEN_W-1:0] idx_ext, len_m1, idx_c, back_pos;
    logic             last;

    assign o_in_stall = i_cfg.busy || i_queue_full;
    assign o_push     = i_in_valid && !o_in_stall;

    assign idx_ext  = LEN_W'(r_index);
    assign len_m1   = i_cfg.len - LEN_W'(1);
    // index left past the end after the length was lowered: treat as last
    assign idx_c    = (idx_ext > len_m1) ? len_m1 : idx_ext;
    assign back_pos = len_m1 - idx_c;
    assign last     = (idx_c == len_m1);

    assign o_job.sample  = i_sample_in;
    assign o_job.in_pos  = idx_c;
    assign o_job.out_pos = back_pos;
    assign o_job.in_act  = (i_cfg.nin > LEN_W'(1)) && (idx_c < i_cfg.nin);
    assign o_job.out_act = (i_cfg.nout > LEN_W'(1)) && (back_pos < i_cfg.nout);
    assign o_job.last    = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else if (o_push) begin
            r_index <= last ? '0 : IDX_W'(idx_c + LEN_W'(1));
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rcef_queue.sv
// ----------------------------------------------------------------------------
// rcef_queue
// Short FIFO of tagged sample requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rcef_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rcef_pkg::t_job i_job,
    input  logic           i_pop,
    output rcef_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);
    import rcef_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_slot [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rcef_back.sv
// ----------------------------------------------------------------------------
// rcef_back
// Gain lookup with interpolation and sample scaling, shared serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rcef_back #(
    parameter int COS_TABLE_DEPTH = rcef_pkg::DEF_COS_TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rcef_pkg::t_fade_cfg                  i_cfg,
    input  logic                                 i_empty,
    output logic                                 o_pop,
    input  rcef_pkg::t_job                       i_job,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic signed [rcef_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                 o_buffer_end
);
    import rcef_pkg::*;

    localparam int ADDR_W = $clog2(COS_TABLE_DEPTH + 1);
    localparam int POS_W  = LEN_W + ADDR_W;
    localparam int FRAC_W = GAIN_W + LEN_W + 1;
    localparam int DVD_W  = (POS_W > FRAC_W) ? POS_W : FRAC_W;
    localparam int CNT_W  = $clog2(DVD_W);
    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

    typedef logic [GAIN_W-1:0] t_tab [0:COS_TABLE_DEPTH];

    // G[k] = round(32768 * sin^2(pi*k / (2*D))), held monotonic
    function automatic t_tab build_tab();
        t_tab        tab;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] g;
        int          k;
        for (k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x  = (HALF_PI_Q30 * 64'(k) + 64'(COS_TABLE_DEPTH / 2)) / COS_TABLE_DEPTH;
            s  = sin_q30(x);
            s2 = (s * s) >> 30;
            g  = (s2 + 64'd16384) >> 15;
            if (g > 64'(ONE_Q15)) begin
                g = 64'(ONE_Q15);
            end
            if (k > 0 && g < 64'(tab[k-1])) begin
                g = 64'(tab[k-1]);
            end
            tab[k] = g[GAIN_W-1:0];
        end
        return tab;
    endfunction

    localparam t_tab GAIN_TAB = build_tab();

    t_back_state r_state, n_state;

    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_last;
    logic                       r_in_act, r_out_act;
    logic [LEN_W-1:0]           r_in_pos, r_out_pos;
    logic [LEN_W-1:0]           r_den;
    logic [DVD_W-1:0]           r_dvd;
    logic [LEN_W-1:0]           r_rem;
    logic [CNT_W-1:0]           r_cnt;
    logic [GAIN_W-1:0]          r_lo, r_hi;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic                       r_buffer_end;

    logic             out_free;
    logic             do_setup, do_div, do_rom, do_muld, do_gmul, do_round, out_load;
    logic             any_act;
    logic [LEN_W-1:0] sel_pos, sel_den;
    logic [POS_W-1:0] pos_mul;
    logic [LEN_W:0]   div_s;
    logic             div_ge;
    logic [LEN_W:0]   div_rem;
    logic             big;
    logic [ADDR_W-1:0] addr_lo, addr_hi;
    logic [GAIN_W-1:0] diff;
    logic [FRAC_W-1:0] frac_t;
    logic [GAIN_W-1:0] gain;
    logic [PROD_W-1:0] abs_p, rnd, rnd_s;

    assign out_free = !r_out_valid || !i_out_stall;
    assign any_act  = r_in_act || r_out_act;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:  if (!i_empty) n_state = BK_SETUP;
            BK_SETUP: n_state = any_act ? BK_DIVQ : BK_OUT;
            BK_DIVQ:  if (r_cnt == '0) n_state = BK_ROM;
            BK_ROM:   n_state = BK_MULD;
            BK_MULD:  n_state = BK_DIVF;
            BK_DIVF:  if (r_cnt == '0) n_state = BK_GMUL;
            BK_GMUL:  n_state = BK_ROUND;
            BK_ROUND: n_state = BK_SETUP;
            BK_OUT:   if (out_free) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop    = 1'b0;
        do_setup = 1'b0;
        do_div   = 1'b0;
        do_rom   = 1'b0;
        do_muld  = 1'b0;
        do_gmul  = 1'b0;
        do_round = 1'b0;
        out_load = 1'b0;
        case (r_state)
            BK_IDLE:  o_pop    = !i_empty;
            BK_SETUP: do_setup = any_act;
            BK_DIVQ:  do_div   = 1'b1;
            BK_ROM:   do_rom   = 1'b1;
            BK_MULD:  do_muld  = 1'b1;
            BK_DIVF:  do_div   = 1'b1;
            BK_GMUL:  do_gmul  = 1'b1;
            BK_ROUND: do_round = 1'b1;
            BK_OUT:   out_load = out_free;
            default:  ;
        endcase
    end

    // fade-in first, then fade-out
    assign sel_pos = r_in_act ? r_in_pos : r_out_pos;
    assign sel_den = r_in_act ? (i_cfg.nin - LEN_W'(1)) : (i_cfg.nout - LEN_W'(1));
    assign pos_mul = POS_W'(sel_pos) * POS_W'(COS_TABLE_DEPTH);

    // restoring divide step, one quotient bit per cycle
    assign div_s   = {r_rem, r_dvd[DVD_W-1]};
    assign div_ge  = div_s >= {1'b0, r_den};
    assign div_rem = div_ge ? (div_s - {1'b0, r_den}) : div_s;

    // past the table end reads G[D] twice, so the interpolation adds nothing
    assign big     = r_dvd >= DVD_W'(COS_TABLE_DEPTH);
    assign addr_lo = big ? ADDR_W'(COS_TABLE_DEPTH) : r_dvd[ADDR_W-1:0];
    assign addr_hi = big ? ADDR_W'(COS_TABLE_DEPTH) : (r_dvd[ADDR_W-1:0] + ADDR_W'(1));

    assign diff   = r_hi - r_lo;
    assign frac_t = FRAC_W'(diff) * FRAC_W'(r_rem) + FRAC_W'(r_den >> 1);
    assign gain   = r_lo + r_dvd[GAIN_W-1:0];

    // round half away from zero
    assign abs_p = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign rnd   = (abs_p + PROD_W'(16384)) >> GAIN_FRAC;
    assign rnd_s = r_prod[PROD_W-1] ? (~rnd + PROD_W'(1)) : rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_in_act    <= 1'b0;
            r_out_act   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_in_act  <= i_job.in_act;
                r_out_act <= i_job.out_act;
            end else if (do_setup) begin
                if (r_in_act) begin
                    r_in_act <= 1'b0;
                end else begin
                    r_out_act <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x       <= i_job.sample;
            r_last    <= i_job.last;
            r_in_pos  <= i_job.in_pos;
            r_out_pos <= i_job.out_pos;
        end
        if (do_setup) begin
            r_den <= sel_den;
            r_dvd <= DVD_W'(pos_mul);
            r_rem <= '0;
            r_cnt <= CNT_W'(DVD_W - 1);
        end else if (do_div) begin
            r_dvd <= {r_dvd[DVD_W-2:0], div_ge};
            r_rem <= div_rem[LEN_W-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end else if (do_muld) begin
            r_dvd <= DVD_W'(frac_t);
            r_rem <= '0;
            r_cnt <= CNT_W'(DVD_W - 1);
        end
        if (do_rom) begin
            r_lo <= GAIN_TAB[addr_lo];
            r_hi <= GAIN_TAB[addr_hi];
        end
        if (do_gmul) begin
            r_prod <= r_x * $signed({1'b0, gain});
        end
        if (do_round) begin
            r_x <= $signed(rnd_s[SAMPLE_W-1:0]);
        end
        if (out_load) begin
            r_sample_out <= r_x;
            r_buffer_end <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_buffer_end = r_buffer_end;

endmodule

`default_nettype wire

FILE: rtl/raised_cosine_edge_fader.sv
// ----------------------------------------------------------------------------
// raised_cosine_edge_fader - raised-cosine fade-in/fade-out of a sample stream
// Per fade on a request the back runs setup, a bit-serial divide (DVD_W = 34
// bits at defaults), table read, multiply, a second divide, gain multiply and
// rounding; with one shared divider it takes no new request until the last is out.
// Synchronous active-low reset: length 1, no fades, index 0; a register write
// stalls input in its own cycle and while lengths are rederived.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module raised_cosine_edge_fader #(
    parameter int MAX_LENGTH      = rcef_pkg::DEF_MAX_LENGTH,
    parameter int COS_TABLE_DEPTH = rcef_pkg::DEF_COS_TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rcef_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rcef_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [rcef_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [rcef_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                 o_buffer_end
);
    import rcef_pkg::*;

    localparam int IDX_W = (MAX_LENGTH >= (1 << LEN_W)) ? LEN_W : $clog2(MAX_LENGTH);

    t_fade_cfg w_cfg;
    t_job      w_push_job, w_pop_job;
    logic      w_push, w_pop, w_full, w_empty;
    logic      w_reg_write;

    assign w_reg_write = i_cfg_we && ((i_cfg_index == REG_BUFFER_LENGTH)
                                   || (i_cfg_index == REG_FADE_IN)
                                   || (i_cfg_index == REG_FADE_OUT));

    rcef_cfg #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    rcef_front #(
        .IDX_W (IDX_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .i_cfg        (w_cfg),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    rcef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    rcef_back #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .i_job        (w_pop_job),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .o_buffer_end (o_buffer_end)
    );

    // no request may slip in while fade lengths are being rederived
    `ASSERT_IMPLIES(a_busy_stalls, i_clk, i_rst_n, w_cfg.busy, o_in_stall)
    `ASSERT_NEXT(a_write_rederives, i_clk, i_rst_n, w_reg_write, w_cfg.busy)
    `ASSERT_IMPLIES(a_full_stalls, i_clk, i_rst_n, w_full, o_in_stall)
    `ASSERT_IMPLIES(a_pop_has_data, i_clk, i_rst_n, w_pop, !w_empty)

endmodule

`default_nettype wire
